### design/pjs_pkg.sv
// ----------------------------------------------------------------------------
// pjs_pkg
// Shared types, register map and helpers for the packet jitter statistics
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package pjs_pkg;

	localparam int unsigned TIME_W    = 64;
	localparam int unsigned SEQ_W     = 64;
	localparam int unsigned LEN_W     = 16;
	localparam int unsigned CNT_W     = 64;
	localparam int unsigned SAMPLE_W  = 32;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam int unsigned IN_DATA_W  = 144;
	localparam int unsigned OUT_DATA_W = 488;

	localparam logic [LEN_W-1:0] MIN_BYTES_RESET = 16'd16;

	typedef enum logic {
		REG_ECHO_MODE = 1'b0,
		REG_MIN_BYTES = 1'b1
	} reg_index_t;

	typedef struct packed {
		logic [LEN_W-1:0]  length_bytes;
		logic [SEQ_W-1:0]  seq_num;
		logic [TIME_W-1:0] arrival_time_ns;
	} item_t;

	typedef struct packed {
		logic             accepted;
		logic [CNT_W-1:0] packets_total;
		logic [CNT_W-1:0] bytes_total;
		logic [SEQ_W-1:0] highest_sequence;
		logic             sequence_seen;
		logic [CNT_W-1:0] lost_total;
	} stat_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
	                                             input logic [CNT_W-1:0] b);
		logic [CNT_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

### design/pjs_apb_regs.sv
// ----------------------------------------------------------------------------
// pjs_apb_regs
// Configuration registers behind an APB-style port: echo mode and minimum
// accepted datagram length.
// ----------------------------------------------------------------------------
`default_nettype none

module pjs_apb_regs (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [pjs_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [pjs_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [pjs_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                   pready,
	output logic                                   echo_mode,
	output logic      [pjs_pkg::LEN_W-1:0]         min_packet_bytes
);

	pjs_pkg::reg_index_t reg_sel;
	logic                wr_en;

	assign reg_sel = pjs_pkg::reg_index_t'(paddr[2]);
	assign wr_en   = psel & penable & pwrite & pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_mode        <= 1'b0;
			min_packet_bytes <= pjs_pkg::MIN_BYTES_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				pjs_pkg::REG_ECHO_MODE: echo_mode <= pwdata[0];
				pjs_pkg::REG_MIN_BYTES: min_packet_bytes <= pwdata[pjs_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			pjs_pkg::REG_ECHO_MODE: prdata = {{(pjs_pkg::APB_DATA_W-1){1'b0}}, echo_mode};
			pjs_pkg::REG_MIN_BYTES:
				prdata = {{(pjs_pkg::APB_DATA_W-pjs_pkg::LEN_W){1'b0}}, min_packet_bytes};
			default: prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/pjs_track.sv
// ----------------------------------------------------------------------------
// pjs_track
// Per-datagram tracking: length check, packet and byte totals, highest
// sequence, loss count, arrival gap and clamped jitter sample.
// ----------------------------------------------------------------------------
`default_nettype none

module pjs_track #(
	parameter int unsigned JITTER_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_en,
	input  wire pjs_pkg::item_t                item_s1,
	input  wire logic                          echo_mode,
	input  wire logic [pjs_pkg::LEN_W-1:0]     min_packet_bytes,
	output pjs_pkg::stat_t                     stat_s2,
	output logic      [JITTER_BITS-1:0]        jitter_s2,
	output logic                               jitter_valid_s2
);

	localparam logic [JITTER_BITS-1:0] JitterLimit = {JITTER_BITS{1'b1}};

	logic [pjs_pkg::TIME_W-1:0] last_arrival_q;
	logic                       last_arrival_valid_q;
	logic [pjs_pkg::TIME_W-1:0] last_gap_q;
	logic                       last_gap_valid_q;
	logic [pjs_pkg::CNT_W-1:0]  packet_count_q;
	logic [pjs_pkg::CNT_W-1:0]  byte_count_q;
	logic [pjs_pkg::SEQ_W-1:0]  max_sequence_q;
	logic                       max_sequence_valid_q;

	logic                       acc;
	logic                       measure;
	logic                       take_sample;
	logic [pjs_pkg::TIME_W-1:0] gap;
	logic [pjs_pkg::TIME_W-1:0] diff;
	logic [JITTER_BITS-1:0]     jitter_clamped;
	logic [pjs_pkg::CNT_W-1:0]  packet_count_n;
	logic [pjs_pkg::CNT_W-1:0]  byte_count_n;
	logic [pjs_pkg::SEQ_W-1:0]  max_sequence_n;
	logic                       max_sequence_valid_n;
	logic                       raise_seq;
	logic [pjs_pkg::CNT_W-1:0]  seq_gap;
	logic [pjs_pkg::CNT_W-1:0]  lost;

	always_comb begin
		acc         = item_s1.length_bytes >= min_packet_bytes;
		measure     = acc & ~echo_mode;
		take_sample = measure & last_arrival_valid_q & last_gap_valid_q;
		gap         = item_s1.arrival_time_ns - last_arrival_q;
		diff        = (gap > last_gap_q) ? gap - last_gap_q : last_gap_q - gap;
		if (diff > {{(pjs_pkg::TIME_W-JITTER_BITS){1'b0}}, JitterLimit})
			jitter_clamped = JitterLimit;
		else
			jitter_clamped = diff[JITTER_BITS-1:0];

		packet_count_n = acc ? pjs_pkg::sat_add(packet_count_q, 64'd1) : packet_count_q;
		byte_count_n   = acc ? pjs_pkg::sat_add(byte_count_q,
		                       {{(pjs_pkg::CNT_W-pjs_pkg::LEN_W){1'b0}}, item_s1.length_bytes})
		                     : byte_count_q;
		raise_seq = acc & (~max_sequence_valid_q | (item_s1.seq_num > max_sequence_q));
		max_sequence_n       = raise_seq ? item_s1.seq_num : max_sequence_q;
		max_sequence_valid_n = max_sequence_valid_q | acc;

		seq_gap = max_sequence_n - packet_count_n;
		if (max_sequence_valid_n && (packet_count_n <= max_sequence_n))
			lost = (&seq_gap) ? seq_gap : seq_gap + 64'd1;
		else
			lost = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_arrival_q       <= '0;
			last_arrival_valid_q <= 1'b0;
			last_gap_q           <= '0;
			last_gap_valid_q     <= 1'b0;
			packet_count_q       <= '0;
			byte_count_q         <= '0;
			max_sequence_q       <= '0;
			max_sequence_valid_q <= 1'b0;
		end else if (item_en) begin
			if (measure) begin
				last_arrival_q       <= item_s1.arrival_time_ns;
				last_arrival_valid_q <= 1'b1;
				if (last_arrival_valid_q) begin
					last_gap_q       <= gap;
					last_gap_valid_q <= 1'b1;
				end
			end
			packet_count_q       <= packet_count_n;
			byte_count_q         <= byte_count_n;
			max_sequence_q       <= max_sequence_n;
			max_sequence_valid_q <= max_sequence_valid_n;
		end
	end

	always_ff @(posedge clk) begin
		if (item_en) begin
			stat_s2.accepted         <= acc;
			stat_s2.packets_total    <= packet_count_n;
			stat_s2.bytes_total      <= byte_count_n;
			stat_s2.highest_sequence <= max_sequence_n;
			stat_s2.sequence_seen    <= max_sequence_valid_n;
			stat_s2.lost_total       <= lost;
			jitter_s2                <= take_sample ? jitter_clamped : '0;
			jitter_valid_s2          <= take_sample;
		end
	end

endmodule

`default_nettype wire

### design/pjs_jitter_acc.sv
// ----------------------------------------------------------------------------
// pjs_jitter_acc
// Jitter square and saturating accumulation of jitter sum, sample count and
// sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module pjs_jitter_acc #(
	parameter int unsigned JITTER_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          sq_en,
	input  wire logic                          acc_en,
	input  wire logic [JITTER_BITS-1:0]        jitter_s2,
	input  wire logic                          jitter_valid_s2,
	output logic      [JITTER_BITS-1:0]        jitter_s3,
	output logic                               jitter_valid_s3,
	output logic      [pjs_pkg::CNT_W-1:0]     jitter_total_q,
	output logic      [pjs_pkg::CNT_W-1:0]     jitter_samples_q,
	output logic      [pjs_pkg::CNT_W-1:0]     jitter_square_total_q
);

	localparam int unsigned SqW = 2 * JITTER_BITS;

	logic [SqW-1:0] square_s3;

	always_ff @(posedge clk) begin
		if (sq_en) begin
			jitter_s3       <= jitter_s2;
			jitter_valid_s3 <= jitter_valid_s2;
			square_s3       <= SqW'(jitter_s2) * SqW'(jitter_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jitter_total_q        <= '0;
			jitter_samples_q      <= '0;
			jitter_square_total_q <= '0;
		end else if (acc_en && jitter_valid_s3) begin
			jitter_total_q <= pjs_pkg::sat_add(jitter_total_q,
			                  {{(pjs_pkg::CNT_W-JITTER_BITS){1'b0}}, jitter_s3});
			jitter_samples_q <= pjs_pkg::sat_add(jitter_samples_q, 64'd1);
			jitter_square_total_q <= pjs_pkg::sat_add(jitter_square_total_q,
			                         {{(pjs_pkg::CNT_W-SqW){1'b0}}, square_s3});
		end
	end

endmodule

`default_nettype wire

### design/packet_jitter_statistics.sv
// ----------------------------------------------------------------------------
// packet_jitter_statistics
// Inter-arrival jitter and traffic statistics over received datagram
// descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one datagram descriptor per transfer (arrival time, sequence
//   number, length). m_* returns one result per descriptor with the running
//   packet, byte, sequence, loss and jitter statistics after that datagram.
//   The APB port sets echo mode and the minimum accepted length; write it
//   only while no descriptor is in flight.
//   From input transfer to output valid, the input register loads at the
//   transfer, then come the tracking stage, the jitter square stage and
//   accumulation into the output register. Throughput is one descriptor
//   per cycle while the output is not stalled; every stage holds its own
//   valid bit, so bubbles are absorbed and s_tready stays high while an
//   output waits, until the four stages are full.
//   When m_tready is low the output holds and the stages behind it fill;
//   s_tready falls only once all are occupied.
//   Reset clears all totals, the arrival and gap history and the pipeline
//   valid bits; echo mode resets to 0 and the minimum length to 16 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_jitter_statistics #(
	parameter int unsigned JITTER_BITS = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [pjs_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [pjs_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [pjs_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                    pready,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// arrival_time_ns[63:0], seq_num[127:64], length_bytes[143:128]
	input  wire logic [pjs_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// accepted[0], packets_total[64:1], bytes_total[128:65],
	// highest_sequence[192:129], sequence_seen[193], jitter_sample[225:194],
	// jitter_valid[226], jitter_total[290:227], jitter_samples[354:291],
	// jitter_square_total[418:355], lost_total[482:419], zero fill above
	output logic      [pjs_pkg::OUT_DATA_W-1:0]     m_tdata
);

	logic                          echo_mode;
	logic [pjs_pkg::LEN_W-1:0]     min_packet_bytes;

	logic                          valid_s1, valid_s2, valid_s3, out_valid_q;
	logic                          ready_s1, ready_s2, ready_s3, ready_out;
	logic                          move_s1, move_s2, move_s3;
	pjs_pkg::item_t                item_s1;

	pjs_pkg::stat_t                stat_s2, stat_s3, stat_q;
	logic [JITTER_BITS-1:0]        jitter_s2, jitter_s3;
	logic                          jitter_valid_s2, jitter_valid_s3;
	logic [JITTER_BITS-1:0]        jitter_sample_q;
	logic                          jitter_valid_q;
	logic [pjs_pkg::CNT_W-1:0]     jitter_total_q, jitter_samples_q, jitter_square_total_q;

	pjs_apb_regs u_regs (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.echo_mode        (echo_mode),
		.min_packet_bytes (min_packet_bytes)
	);

	assign ready_out = ~out_valid_q | m_tready;
	assign ready_s3  = ~valid_s3 | ready_out;
	assign ready_s2  = ~valid_s2 | ready_s3;
	assign ready_s1  = ~valid_s1 | ready_s2;
	assign s_tready  = ready_s1;
	assign move_s1   = valid_s1 & ready_s2;
	assign move_s2   = valid_s2 & ready_s3;
	assign move_s3   = valid_s3 & ready_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready_s1)  valid_s1    <= s_tvalid;
			if (ready_s2)  valid_s2    <= valid_s1;
			if (ready_s3)  valid_s3    <= valid_s2;
			if (ready_out) out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && ready_s1)
			item_s1 <= pjs_pkg::item_t'(s_tdata);
	end

	pjs_track #(
		.JITTER_BITS (JITTER_BITS)
	) u_track (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_en          (move_s1),
		.item_s1          (item_s1),
		.echo_mode        (echo_mode),
		.min_packet_bytes (min_packet_bytes),
		.stat_s2          (stat_s2),
		.jitter_s2        (jitter_s2),
		.jitter_valid_s2  (jitter_valid_s2)
	);

	always_ff @(posedge clk) begin
		if (move_s2)
			stat_s3 <= stat_s2;
	end

	pjs_jitter_acc #(
		.JITTER_BITS (JITTER_BITS)
	) u_jitter_acc (
		.clk                   (clk),
		.arst_n                (arst_n),
		.sq_en                 (move_s2),
		.acc_en                (move_s3),
		.jitter_s2             (jitter_s2),
		.jitter_valid_s2       (jitter_valid_s2),
		.jitter_s3             (jitter_s3),
		.jitter_valid_s3       (jitter_valid_s3),
		.jitter_total_q        (jitter_total_q),
		.jitter_samples_q      (jitter_samples_q),
		.jitter_square_total_q (jitter_square_total_q)
	);

	always_ff @(posedge clk) begin
		if (move_s3) begin
			stat_q          <= stat_s3;
			jitter_sample_q <= jitter_s3;
			jitter_valid_q  <= jitter_valid_s3;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {
		{(pjs_pkg::OUT_DATA_W-483){1'b0}},
		stat_q.lost_total,
		jitter_square_total_q,
		jitter_samples_q,
		jitter_total_q,
		jitter_valid_q,
		{(pjs_pkg::SAMPLE_W-JITTER_BITS){1'b0}}, jitter_sample_q,
		stat_q.sequence_seen,
		stat_q.highest_sequence,
		stat_q.bytes_total,
		stat_q.packets_total,
		stat_q.accepted
	};

	a_jitter_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!jitter_valid_q || stat_q.accepted))
		else $error("jitter sample reported for a rejected datagram");

	a_idle_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !jitter_valid_q) |-> (jitter_sample_q == '0))
		else $error("jitter sample non-zero without a valid sample");

	a_no_seq_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !stat_q.sequence_seen) |->
		(stat_q.lost_total == '0 && stat_q.highest_sequence == '0))
		else $error("loss or sequence reported before any datagram accepted");

	a_samples_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		jitter_samples_q >= $past(jitter_samples_q))
		else $error("jitter sample count decreased");

	a_stall_holds_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> $stable(jitter_total_q))
		else $error("jitter total changed while output stalled");

endmodule

`default_nettype wire

### verif/pjs_stats_checker.sv
// ----------------------------------------------------------------------------
// Packet jitter statistics checker
// Snoops the register port and both streams of the packet jitter statistics
// block. Keeps its own copy of the traffic and jitter totals, works out the
// statistics report due for every descriptor transfer, and compares each
// report transfer field by field with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module pjs_stats_checker
	import pjs_pkg::*;
#(
	parameter int unsigned JITTER_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// arrival_time_ns[63:0], seq_num[127:64], length_bytes[143:128]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// accepted[0], packets_total[64:1], bytes_total[128:65],
	// highest_sequence[192:129], sequence_seen[193], jitter_sample[225:194],
	// jitter_valid[226], jitter_total[290:227], jitter_samples[354:291],
	// jitter_square_total[418:355], lost_total[482:419], zero fill above
	input  logic [OUT_DATA_W-1:0] m_tdata,
	output int unsigned           pending,
	output int unsigned           mismatches,
	output int unsigned           reports_checked,
	output int unsigned           samples_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [APB_ADDR_W-1:0] ECHO_ADDR = {REG_ECHO_MODE, 2'b00};
	localparam logic [APB_ADDR_W-1:0] MIN_ADDR  = {REG_MIN_BYTES, 2'b00};
	localparam logic [63:0] JITTER_MAX = (64'd1 << JITTER_BITS) - 64'd1;

	typedef struct packed {
		logic [OUT_DATA_W-484:0] fill;
		logic [CNT_W-1:0]        lost_total;
		logic [CNT_W-1:0]        jitter_square_total;
		logic [CNT_W-1:0]        jitter_samples;
		logic [CNT_W-1:0]        jitter_total;
		logic                    jitter_valid;
		logic [SAMPLE_W-1:0]     jitter_sample;
		logic                    sequence_seen;
		logic [SEQ_W-1:0]        highest_sequence;
		logic [CNT_W-1:0]        bytes_total;
		logic [CNT_W-1:0]        packets_total;
		logic                    accepted;
	} stat_report_t;

	logic             echo_on;
	logic [LEN_W-1:0] min_bytes;
	logic [63:0]      prev_arrival;
	logic             arrival_seen;
	logic [63:0]      prev_gap;
	logic             gap_seen;
	logic [63:0]      pkt_count;
	logic [63:0]      byte_sum;
	logic [63:0]      top_seq;
	logic             top_seq_seen;
	logic [63:0]      jit_sum;
	logic [63:0]      jit_count;
	logic [63:0]      jit_sq_sum;

	stat_report_t report_q[$];

	function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[64] ? {64{1'b1}} : sum[63:0];
	endfunction

	function automatic stat_report_t account_datagram(input logic [63:0] arrival,
	                                                  input logic [63:0] seq,
	                                                  input logic [LEN_W-1:0] len);
		stat_report_t r;
		logic [63:0] gap;
		logic [63:0] dev;
		r = '0;
		r.accepted = (len >= min_bytes);
		if (r.accepted) begin
			if (!echo_on) begin
				if (arrival_seen) begin
					gap = arrival - prev_arrival;
					if (gap_seen) begin
						dev = (gap > prev_gap) ? gap - prev_gap : prev_gap - gap;
						if (dev > JITTER_MAX)
							dev = JITTER_MAX;
						r.jitter_sample = dev[SAMPLE_W-1:0];
						r.jitter_valid = 1'b1;
						jit_sum = add_clamped(jit_sum, dev);
						jit_count = add_clamped(jit_count, 64'd1);
						jit_sq_sum = add_clamped(jit_sq_sum, dev * dev);
					end
					prev_gap = gap;
					gap_seen = 1'b1;
				end
				prev_arrival = arrival;
				arrival_seen = 1'b1;
			end
			pkt_count = add_clamped(pkt_count, 64'd1);
			byte_sum = add_clamped(byte_sum, {48'd0, len});
			if (!top_seq_seen || seq > top_seq) begin
				top_seq = seq;
				top_seq_seen = 1'b1;
			end
		end
		r.packets_total = pkt_count;
		r.bytes_total = byte_sum;
		r.highest_sequence = top_seq;
		r.sequence_seen = top_seq_seen;
		r.jitter_total = jit_sum;
		r.jitter_samples = jit_count;
		r.jitter_square_total = jit_sq_sum;
		if (top_seq_seen && pkt_count <= top_seq)
			r.lost_total = add_clamped(top_seq - pkt_count, 64'd1);
		return r;
	endfunction

	task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s: expected %0h, actual %0h", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		stat_report_t got;
		stat_report_t want;
		if (!arst_n) begin
			echo_on = 1'b0;
			min_bytes = MIN_BYTES_RESET;
			prev_arrival = '0;
			arrival_seen = 1'b0;
			prev_gap = '0;
			gap_seen = 1'b0;
			pkt_count = '0;
			byte_sum = '0;
			top_seq = '0;
			top_seq_seen = 1'b0;
			jit_sum = '0;
			jit_count = '0;
			jit_sq_sum = '0;
			report_q.delete();
			mismatches = 0;
			reports_checked = 0;
			samples_checked = 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ECHO_ADDR: echo_on = pwdata[0];
					MIN_ADDR:  min_bytes = pwdata[LEN_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = stat_report_t'(m_tdata);
				if (report_q.size() == 0) begin
					mismatches++;
					$display("%0t report transfer with none outstanding: expected none, actual %0h",
					         $time, m_tdata);
				end else begin
					want = report_q.pop_front();
					reports_checked++;
					if (want.jitter_valid)
						samples_checked++;
					check_field("accepted", 64'(want.accepted), 64'(got.accepted));
					check_field("packets_total", want.packets_total, got.packets_total);
					check_field("bytes_total", want.bytes_total, got.bytes_total);
					check_field("highest_sequence", want.highest_sequence, got.highest_sequence);
					check_field("sequence_seen", 64'(want.sequence_seen), 64'(got.sequence_seen));
					check_field("jitter_sample", 64'(want.jitter_sample), 64'(got.jitter_sample));
					check_field("jitter_valid", 64'(want.jitter_valid), 64'(got.jitter_valid));
					check_field("jitter_total", want.jitter_total, got.jitter_total);
					check_field("jitter_samples", want.jitter_samples, got.jitter_samples);
					check_field("jitter_square_total", want.jitter_square_total,
					            got.jitter_square_total);
					check_field("lost_total", want.lost_total, got.lost_total);
					check_field("zero fill", 64'(want.fill), 64'(got.fill));
				end
			end
			if (s_tvalid && s_tready)
				report_q.push_back(account_datagram(s_tdata[63:0], s_tdata[127:64],
				                                    s_tdata[143:128]));
			pending <= report_q.size();
		end
	end

endmodule

### verif/tb_packet_jitter_statistics.sv
// ----------------------------------------------------------------------------
// Packet jitter statistics testbench
// Drives datagram descriptors into the block: a directed run over the edge
// cases first, then eight phases of random traffic under different register
// settings and back-pressure patterns. A separate checker predicts and
// compares every report; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_packet_jitter_statistics;
	import pjs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned JITTER_BITS = 32;
	localparam logic [APB_ADDR_W-1:0] ECHO_ADDR = {REG_ECHO_MODE, 2'b00};
	localparam logic [APB_ADDR_W-1:0] MIN_ADDR  = {REG_MIN_BYTES, 2'b00};
	localparam logic [63:0] JITTER_MAX = (64'd1 << JITTER_BITS) - 64'd1;
	localparam int unsigned PIPE_LATENCY = 4;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 50;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// arrival_time_ns[63:0], seq_num[127:64], length_bytes[143:128]
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// accepted[0], packets_total[64:1], bytes_total[128:65],
	// highest_sequence[192:129], sequence_seen[193], jitter_sample[225:194],
	// jitter_valid[226], jitter_total[290:227], jitter_samples[354:291],
	// jitter_square_total[418:355], lost_total[482:419], zero fill above
	logic [OUT_DATA_W-1:0] m_tdata;

	int unsigned pending;
	int unsigned mismatches;
	int unsigned reports_checked;
	int unsigned samples_checked;

	int unsigned send_idle = 0;
	int unsigned stall_pct = 0;
	int unsigned sent_count = 0;
	int unsigned cycle_count = 0;
	logic [63:0] clock_ns;
	logic [63:0] next_seq;
	logic [15:0] min_len = MIN_BYTES_RESET;

	packet_jitter_statistics #(
		.JITTER_BITS(JITTER_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	pjs_stats_checker #(
		.JITTER_BITS(JITTER_BITS)
	) stats_check (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.pending(pending),
		.mismatches(mismatches),
		.reports_checked(reports_checked),
		.samples_checked(samples_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_descriptor(input logic [63:0] stamp, input logic [63:0] seq,
	                               input logic [15:0] len);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {len, seq, stamp};
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	// hold the stream until every report is back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		logic [63:0] stamp;
		logic [63:0] seq;
		logic [15:0] len;
		int unsigned kind;
		logic        echo_sel;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_descriptor(64'd0, 64'd0, 16'd15);
		send_descriptor(64'd0, 64'd0, 16'd0);
		send_descriptor(64'd0, 64'd0, 16'd16);
		send_descriptor(64'd1000, 64'd1, 16'hFFFF);
		send_descriptor(64'd2000, 64'd12, 16'd16);
		send_descriptor(64'd2000, 64'd13, 16'd100);
		send_descriptor(64'd2000, 64'd5, 16'd20);
		send_descriptor(64'd1500, 64'd14, 16'd64);
		send_descriptor(64'd1600, 64'd15, 16'd64);
		send_descriptor(64'd1700, 64'd16, 16'd64);
		send_descriptor(64'd1800 + JITTER_MAX, 64'd17, 16'd64);
		send_descriptor(64'd1900 + JITTER_MAX, 64'd18, 16'd64);
		send_descriptor(64'd2000 + JITTER_MAX + (64'd1 << 32), 64'd19, 16'd64);
		send_descriptor({64{1'b1}}, {64{1'b1}}, 16'd16);
		send_descriptor(64'd0, 64'd0, 16'd1500);
		send_descriptor(64'd100, 64'h8000_0000_0000_0000, 16'd15);
		send_descriptor(64'd200, 64'h8000_0000_0000_0000, 16'd16);

		clock_ns = 64'd1000;
		next_seq = 64'd20;
		for (int p = 0; p < PHASES; p++) begin
			drain();
			repeat (PIPE_LATENCY + 2) @(posedge clk);
			case (p)
				0: begin echo_sel = 1'b0; min_len = 16'd16;    send_idle = 0;  stall_pct = 0;  end
				1: begin echo_sel = 1'b0; min_len = 16'd0;     send_idle = 50; stall_pct = 0;  end
				2: begin echo_sel = 1'b1; min_len = 16'd1;     send_idle = 0;  stall_pct = 50; end
				3: begin echo_sel = 1'b0; min_len = 16'd64;    send_idle = 16; stall_pct = 16; end
				4: begin echo_sel = 1'b0; min_len = 16'hFFFF;  send_idle = 0;  stall_pct = 0;  end
				5: begin echo_sel = 1'b0; min_len = 16'd1;     send_idle = 50; stall_pct = 0;  end
				6: begin echo_sel = 1'b1; min_len = 16'd0;     send_idle = 0;  stall_pct = 50; end
				default: begin echo_sel = 1'b0; min_len = 16'd16; send_idle = 16; stall_pct = 16; end
			endcase
			reg_write(ECHO_ADDR, {31'd0, echo_sel});
			reg_write(MIN_ADDR, {16'd0, min_len});
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				kind = $urandom_range(99);
				clock_ns += 64'd1000 + 64'($urandom_range(300));
				next_seq += ($urandom_range(9) == 0) ? 64'($urandom_range(6, 2)) : 64'd1;
				stamp = clock_ns;
				seq = next_seq;
				len = (min_len > 16'd1500) ? 16'hFFFF : 16'($urandom_range(1500, min_len));
				if (kind >= 95) begin
					stamp = {$urandom, $urandom};
					seq = {$urandom, $urandom};
					len = 16'($urandom);
				end else if (kind >= 85) begin
					clock_ns += {$urandom, $urandom} >> $urandom_range(63, 24);
					stamp = clock_ns;
					seq = next_seq - 64'($urandom_range(4));
				end else if (kind >= 75) begin
					len = (min_len == 16'd0) ? 16'($urandom_range(15)) :
					                           16'($urandom_range(min_len - 16'd1, 0));
				end
				send_descriptor(stamp, seq, len);
				if (p == 5 && i == PHASE_ITEMS / 2)
					drain();
			end
		end

		drain();
		repeat (PIPE_LATENCY + 4) @(posedge clk);
		$display("%0d descriptors across %0d register settings and four back-pressure patterns",
		         sent_count, PHASES + 1);
		$display("%0d reports compared, %0d of them with a jitter sample",
		         reports_checked, samples_checked);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
